// ===== design/segment_reorder_window_macros.svh =====
// Assertion macros for the segment reorder window.
// Included by the checker; depends on nothing else.
`ifndef SEGMENT_REORDER_WINDOW_MACROS_SVH
`define SEGMENT_REORDER_WINDOW_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SGRW_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the default clock and reset names.
`define SGRW_ASSERT(lbl, prop, msg) \
  `SGRW_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== design/sgrw_pkg.sv =====
// Shared types and constants of the segment reorder window.
// No dependencies; every other file but the macro header imports it.
package sgrw_pkg;

  // Fixed field widths.
  localparam int OFF_W      = 30;
  localparam int ADDR_W     = 32;
  localparam int PORT_W     = 16;
  localparam int TAG_W      = 16;
  localparam int BYTES_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILE_LENGTH   = 2'd0,
    CFG_EXPECTED_ADDR = 2'd1,
    CFG_EXPECTED_PORT = 2'd2
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RELEASE
  } state_e;

  // Control handed to every cell of the window.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  // Received segment descriptor.
  typedef struct packed {
    logic [OFF_W-1:0]  seg_start;
    logic [TAG_W-1:0]  payload_tag;
    logic [ADDR_W-1:0] sender_addr;
    logic [PORT_W-1:0] sender_port;
    logic              is_data;
  } seg_req_t;

  // Released in-order segment.
  typedef struct packed {
    logic [TAG_W-1:0]   out_tag;
    logic [BYTES_W-1:0] out_bytes;
    logic               last_of_run;
    logic               file_complete;
  } rel_req_t;

endpackage

// ===== design/sgrw_if.sv =====
// Valid/ready channel interfaces for segment descriptors and releases.
// Depends on sgrw_pkg for the payload types.
interface sgrw_seg_if import sgrw_pkg::*; ();
  logic     valid;
  logic     ready;
  seg_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sgrw_rel_if import sgrw_pkg::*; ();
  logic     valid;
  logic     ready;
  rel_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/sgrw_cell.sv =====
// One slot of the receive window: a valid bit and a stored payload tag.
// Depends on sgrw_pkg for the cell control struct.
module sgrw_cell import sgrw_pkg::*; #(
  parameter int TAG_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic [TAG_BITS-1:0] load_tag_i,
  input  logic                nbr_valid_i,
  input  logic [TAG_BITS-1:0] nbr_tag_i,
  output logic                valid_o,
  output logic [TAG_BITS-1:0] tag_o
);

  logic                valid_q;
  logic [TAG_BITS-1:0] tag_q;

  // The valid bit takes the neighbor's on a slide, or sets on a load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= nbr_valid_i;
    end else if (ctrl_i.load) begin
      valid_q <= 1'b1;
    end
  end

  // The tag follows the same moves; a duplicate load overwrites it.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      tag_q <= nbr_tag_i;
    end else if (ctrl_i.load) begin
      tag_q <= load_tag_i;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;

endmodule

// ===== design/segment_reorder_window.sv =====
// Segment reorder window: accepts one request, steps over the window slots
// one at a time to place it (a screened-out request skips this), then releases the
// in-order segments at the head one by one, holding while the output stalls.
// The slot search is serial, and the cell chain slides one slot per release.
// Reset clears slot valid bits, offset, state, config and output valid; no sweep.
module segment_reorder_window import sgrw_pkg::*; #(
  parameter int WINDOW_SLOTS  = 32,
  parameter int SEGMENT_BYTES = 1000,
  parameter int TAG_BITS      = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  sgrw_seg_if.sink              seg_i,
  sgrw_rel_if.source            rel_o
);

  localparam int IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam logic [OFF_W-1:0] SEG_OFF  = OFF_W'(SEGMENT_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SLOTS - 1);

  state_e state_q, state_d;

  logic [OFF_W-1:0]  file_len_q;
  logic [ADDR_W-1:0] exp_addr_q;
  logic [PORT_W-1:0] exp_port_q;
  logic [OFF_W-1:0]  next_off_q;

  logic [OFF_W-1:0]    dist_q;
  logic [IDX_W-1:0]    idx_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [OFF_W-1:0]    remain_q;
  logic                out_valid_q;
  rel_req_t            out_q;

  logic                cell_valid [WINDOW_SLOTS];
  logic [TAG_BITS-1:0] cell_tag   [WINDOW_SLOTS];
  logic                second_valid;

  logic                seg_fire, file_done, seg_ok;
  logic [OFF_W-1:0]    diff, remain_in;
  logic [31:0]         tag_wide, head_tag_wide;
  logic [TAG_BITS-1:0] tag_in;
  logic                head_live, dist_fits;
  logic                load_en, can_emit, do_release;
  logic [OFF_W-1:0]    bytes_w;
  logic                complete;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_len_q <= '0;
      exp_addr_q <= '0;
      exp_port_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FILE_LENGTH:   file_len_q <= cfg_wdata_i[OFF_W-1:0];
        CFG_EXPECTED_ADDR: exp_addr_q <= cfg_wdata_i[ADDR_W-1:0];
        CFG_EXPECTED_PORT: exp_port_q <= cfg_wdata_i[PORT_W-1:0];
        default: ;
      endcase
    end
  end

  // Request screening against the peer, the header and the window start.
  assign seg_fire  = seg_i.valid && seg_i.ready;
  assign file_done = next_off_q >= file_len_q;
  assign diff      = seg_i.data.seg_start - next_off_q;
  assign remain_in = file_len_q - next_off_q;
  assign seg_ok    = (seg_i.data.sender_addr == exp_addr_q) &&
                     (seg_i.data.sender_port == exp_port_q) &&
                     seg_i.data.is_data &&
                     (seg_i.data.seg_start >= next_off_q) &&
                     (seg_i.data.seg_start < file_len_q);
  assign tag_wide  = 32'(seg_i.data.payload_tag);
  assign tag_in    = tag_wide[TAG_BITS-1:0];

  // Head of the window and the size of the segment it holds.
  assign head_live = cell_valid[0] && (remain_q != '0);
  assign dist_fits = dist_q < SEG_OFF;
  assign bytes_w   = (remain_q < SEG_OFF) ? remain_q : SEG_OFF;
  assign complete  = remain_q <= SEG_OFF;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (seg_fire && !file_done) begin
          state_d = seg_ok ? ST_SEARCH : ST_RELEASE;
        end
      end
      ST_SEARCH: begin
        if (dist_fits || (idx_q == LAST_IDX)) begin
          state_d = ST_RELEASE;
        end
      end
      ST_RELEASE: begin
        if (!head_live) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    seg_i.ready = (state_q == ST_IDLE);
    load_en     = (state_q == ST_SEARCH) && dist_fits;
    can_emit    = !out_valid_q || rel_o.ready;
    do_release  = (state_q == ST_RELEASE) && head_live && can_emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Window offset advances by the bytes of each released segment.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_off_q <= '0;
    end else if (do_release) begin
      next_off_q <= next_off_q + bytes_w;
    end
  end

  // Serial slot search: step one segment size per cycle.
  always_ff @(posedge clk_i) begin
    if (seg_fire) begin
      dist_q <= diff;
      idx_q  <= '0;
      tag_q  <= tag_in;
    end else if ((state_q == ST_SEARCH) && !dist_fits) begin
      dist_q <= dist_q - SEG_OFF;
      idx_q  <= idx_q + 1'b1;
    end
  end

  // Bytes left in the file, counted down as segments are released.
  always_ff @(posedge clk_i) begin
    if (seg_fire) begin
      remain_q <= remain_in;
    end else if (do_release) begin
      remain_q <= remain_q - bytes_w;
    end
  end

  // Output register for released segments.
  assign head_tag_wide = 32'(cell_tag[0]);

  always_ff @(posedge clk_i) begin
    if (do_release) begin
      out_q.out_tag       <= head_tag_wide[TAG_W-1:0];
      out_q.out_bytes     <= bytes_w[BYTES_W-1:0];
      out_q.last_of_run   <= complete || !second_valid;
      out_q.file_complete <= complete;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_release) begin
      out_valid_q <= 1'b1;
    end else if (rel_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rel_o.valid = out_valid_q;
  assign rel_o.data  = out_q;

  // Chain of window cells; each slides toward the head on a release.
  for (genvar i = 0; i < WINDOW_SLOTS; i++) begin : g_cell
    cell_ctrl_t          ctrl;
    logic                nbr_valid;
    logic [TAG_BITS-1:0] nbr_tag;

    assign ctrl.shift = do_release;
    assign ctrl.load  = load_en && (idx_q == IDX_W'(i));

    if (i == WINDOW_SLOTS - 1) begin : g_tail
      assign nbr_valid = 1'b0;
      assign nbr_tag   = '0;
    end else begin : g_body
      assign nbr_valid = cell_valid[i+1];
      assign nbr_tag   = cell_tag[i+1];
    end

    sgrw_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .load_tag_i  (tag_q),
      .nbr_valid_i (nbr_valid),
      .nbr_tag_i   (nbr_tag),
      .valid_o     (cell_valid[i]),
      .tag_o       (cell_tag[i])
    );
  end

  // Whether a second segment waits behind the head.
  if (WINDOW_SLOTS > 1) begin : g_second
    assign second_valid = cell_valid[1];
  end else begin : g_single
    assign second_valid = 1'b0;
  end

endmodule

// ===== design/sgrw_checker.sv =====
// Port-level checker for the segment reorder window, with its bind.
// Depends on sgrw_pkg and segment_reorder_window_macros.svh.
`include "segment_reorder_window_macros.svh"

module sgrw_assert_checker import sgrw_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     seg_ready_i,
  input logic     rel_valid_i,
  input logic     rel_ready_i,
  input rel_req_t rel_data_i
);

  // A stalled release holds its request.
  `SGRW_ASSERT(a_rel_hold, rel_valid_i && !rel_ready_i |=> rel_valid_i && $stable(rel_data_i), "release request changed while stalled")

  // The segment that completes the file ends its run.
  `SGRW_ASSERT(a_complete_last, rel_valid_i && rel_data_i.file_complete |-> rel_data_i.last_of_run, "file completed without last of run")

  // While a run is still open, no new descriptor is taken.
  `SGRW_ASSERT(a_run_blocks_input, rel_valid_i && !rel_data_i.last_of_run |-> !seg_ready_i, "descriptor taken in the middle of a run")

  // A release only starts out of the release phase.
  `SGRW_ASSERT(a_release_origin, $rose(rel_valid_i) |-> !$past(seg_ready_i), "release appeared while idle")

endmodule

bind segment_reorder_window sgrw_assert_checker u_sgrw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .seg_ready_i (seg_i.ready),
  .rel_valid_i (rel_o.valid),
  .rel_ready_i (rel_o.ready),
  .rel_data_i  (rel_o.data)
);

// ===== test/sgrw_checker.sv =====
// Scoreboard for the segment reorder window: watches the register port and both channels.
// Depends on sgrw_pkg for types and on sgrw_if for the channel interfaces.
module sgrw_checker import sgrw_pkg::*; #(
  parameter int WINDOW_SLOTS  = 32,
  parameter int SEGMENT_BYTES = 1000,
  parameter int TAG_BITS      = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  sgrw_seg_if                   seg_mon,
  sgrw_rel_if                   rel_mon,
  output int                    pending_o,
  output int                    fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the registers and of the receive window.
  logic [OFF_W-1:0]        file_len;
  logic [ADDR_W-1:0]       peer_addr;
  logic [PORT_W-1:0]       peer_port;
  logic [OFF_W-1:0]        win_base;
  logic [WINDOW_SLOTS-1:0] slot_full;
  logic [TAG_W-1:0]        slot_tag [WINDOW_SLOTS];
  rel_req_t                release_q [$];
  rel_req_t                oldest;

  // Report one field that differs from its prediction.
  task automatic note_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  // Place an accepted segment request, then queue the in-order run at the window head.
  task automatic take_segment(input seg_req_t s);
    logic [OFF_W-1:0] slot_idx;
    logic [OFF_W-1:0] remain;
    logic [OFF_W-1:0] chunk;
    logic [TAG_W-1:0] kept;
    rel_req_t         r;
    int               released;
    released = 0;
    kept = s.payload_tag & TAG_W'((64'd1 << TAG_BITS) - 64'd1);
    // A finished file drops everything, including a zero length.
    if (win_base >= file_len) return;
    if (s.sender_addr == peer_addr && s.sender_port == peer_port && s.is_data &&
        s.seg_start >= win_base && s.seg_start < file_len) begin
      slot_idx = OFF_W'((s.seg_start - win_base) / SEGMENT_BYTES);
      if (slot_idx < WINDOW_SLOTS) begin
        slot_full[slot_idx] = 1'b1;
        slot_tag[slot_idx]  = kept;
      end
    end
    // Release filled slots from the head; the final segment is cut to the bytes left.
    while (released < WINDOW_SLOTS && slot_full[0] && win_base < file_len) begin
      remain          = file_len - win_base;
      chunk           = (remain < SEGMENT_BYTES) ? remain : OFF_W'(SEGMENT_BYTES);
      r.out_tag       = slot_tag[0];
      r.out_bytes     = chunk[BYTES_W-1:0];
      r.last_of_run   = 1'b0;
      win_base        = win_base + chunk;
      r.file_complete = (win_base >= file_len);
      slot_full       = slot_full >> 1;
      for (int i = 0; i + 1 < WINDOW_SLOTS; i++) slot_tag[i] = slot_tag[i+1];
      slot_tag[WINDOW_SLOTS-1] = '0;
      release_q.push_back(r);
      released++;
    end
    if (released > 0) begin
      r = release_q.pop_back();
      r.last_of_run = 1'b1;
      release_q.push_back(r);
    end
  endtask

  // Register writes, release checks and predictions, all on the sampled edge values.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_len  = '0;
      peer_addr = '0;
      peer_port = '0;
      win_base  = '0;
      slot_full = '0;
      release_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FILE_LENGTH:   file_len  = cfg_wdata_i[OFF_W-1:0];
          CFG_EXPECTED_ADDR: peer_addr = cfg_wdata_i[ADDR_W-1:0];
          CFG_EXPECTED_PORT: peer_port = cfg_wdata_i[PORT_W-1:0];
          default: ;
        endcase
      end
      if (rel_mon.valid && rel_mon.ready) begin
        if (release_q.size() == 0) begin
          $display("%0t: release request with none expected, actual tag 0x%0h bytes %0d",
                   $time, rel_mon.data.out_tag, rel_mon.data.out_bytes);
          fail_count_o++;
        end else begin
          oldest = release_q.pop_front();
          note_field("out_tag", 32'(oldest.out_tag), 32'(rel_mon.data.out_tag));
          note_field("out_bytes", 32'(oldest.out_bytes), 32'(rel_mon.data.out_bytes));
          note_field("last_of_run", 32'(oldest.last_of_run), 32'(rel_mon.data.last_of_run));
          note_field("file_complete", 32'(oldest.file_complete),
                     32'(rel_mon.data.file_complete));
        end
      end
      if (seg_mon.valid && seg_mon.ready) take_segment(seg_mon.data);
      pending_o <= release_q.size();
    end
  end

endmodule

// ===== test/tb_segment_reorder_window.sv =====
// Testbench top for the segment reorder window: clock, reset, stimulus and verdict.
// Depends on sgrw_pkg, sgrw_if, the block itself and the sgrw_checker scoreboard.
module tb_segment_reorder_window;
  timeunit 1ns;
  timeprecision 1ps;
  import sgrw_pkg::*;

  localparam int WINDOW_SLOTS    = 32;
  localparam int SEGMENT_BYTES   = 1000;
  localparam int TAG_BITS        = 16;
  localparam int RANDOM_SEGMENTS = 125;
  localparam int SETTLE_CYCLES   = 80;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam logic [OFF_W-1:0]     OFF_MAX        = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_LIGHT} stall_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  sgrw_seg_if seg_ch ();
  sgrw_rel_if rel_ch ();

  int pending;
  int fail_count;
  int cycle_count;
  int sent_count;
  int release_count;
  int setting_count;
  int random_done;
  int burst_left;

  // Stimulus-side view of the window, valid whenever the block is idle.
  logic [OFF_W-1:0]  file_len;
  logic [OFF_W-1:0]  win_base;
  logic [ADDR_W-1:0] peer_addr;
  logic [PORT_W-1:0] peer_port;

  segment_reorder_window #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .SEGMENT_BYTES(SEGMENT_BYTES),
    .TAG_BITS     (TAG_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .seg_i      (seg_ch),
    .rel_o      (rel_ch)
  );

  sgrw_checker #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .SEGMENT_BYTES(SEGMENT_BYTES),
    .TAG_BITS     (TAG_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .seg_mon     (seg_ch),
    .rel_mon     (rel_ch),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  // Free-running 2 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog on the total cycle count.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d releases pending.", cycle_count, pending);
    $display("[segment_reorder_window] ERROR");
    $finish;
  end

  // Release receiver: stalls follow stretches of a randomly chosen pattern.
  initial begin
    stall_e mode;
    int     span;
    rel_ch.ready <= 1'b0;
    release_count = 0;
    forever begin
      mode = stall_e'($urandom_range(0, 3));
      span = $urandom_range(10, 60);
      repeat (span) begin
        @(posedge clk_i);
        if (rel_ch.valid && rel_ch.ready) release_count++;
        case (mode)
          STALL_NONE:  rel_ch.ready <= 1'b1;
          STALL_HALF:  rel_ch.ready <= ($urandom_range(0, 1) == 0);
          STALL_HEAVY: rel_ch.ready <= ($urandom_range(0, 3) == 0);
          default:     rel_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic seg_req_t make_seg(input logic [OFF_W-1:0] start,
                                        input logic [TAG_W-1:0] tag,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic [PORT_W-1:0] port,
                                        input logic data);
    seg_req_t s;
    s.seg_start   = start;
    s.payload_tag = tag;
    s.sender_addr = addr;
    s.sender_port = port;
    s.is_data     = data;
    return s;
  endfunction

  // A DATA request from the configured peer.
  function automatic seg_req_t good_seg(input logic [OFF_W-1:0] start,
                                        input logic [TAG_W-1:0] tag);
    return make_seg(start, tag, peer_addr, peer_port, 1'b1);
  endfunction

  function automatic logic [TAG_W-1:0] random_tag();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return TAG_W'($urandom());
    endcase
  endfunction

  // A request the window should drop or that lands off the normal order.
  function automatic seg_req_t noise_seg(input logic [OFF_W-1:0] head);
    logic [OFF_W-1:0] start;
    start = head + OFF_W'($urandom_range(0, WINDOW_SLOTS * SEGMENT_BYTES - 1));
    case ($urandom_range(0, 6))
      0: return make_seg(start, random_tag(), peer_addr ^ (32'd1 << $urandom_range(0, 31)),
                         peer_port, 1'b1);
      1: return make_seg(start, random_tag(), peer_addr,
                         peer_port ^ (16'd1 << $urandom_range(0, 15)), 1'b1);
      2: return make_seg(start, random_tag(), peer_addr, peer_port, 1'b0);
      3: return good_seg(head - OFF_W'($urandom_range(1, SEGMENT_BYTES)), random_tag());
      4: return good_seg(head + OFF_W'(WINDOW_SLOTS * SEGMENT_BYTES + $urandom_range(0, 5000)),
                         random_tag());
      5: return good_seg(file_len + OFF_W'($urandom_range(0, 3000)), random_tag());
      default: return good_seg(start, random_tag());
    endcase
  endfunction

  // Offer one segment request, with bursts and random gaps between them.
  task automatic send_seg(input seg_req_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        seg_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    seg_ch.valid <= 1'b1;
    seg_ch.data  <= s;
    @(posedge clk_i);
    while (!seg_ch.ready) @(posedge clk_i);
    sent_count++;
  endtask

  // Wait for every predicted release, then let a dropped request drain.
  task automatic settle();
    seg_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all registers, plus the unused index, which must have no effect.
  task automatic configure(input logic [CFG_DATA_W-1:0] len_word,
                           input logic [ADDR_W-1:0] addr,
                           input logic [PORT_W-1:0] port);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{CFG_UNUSED_IDX, CFG_FILE_LENGTH, CFG_EXPECTED_ADDR, CFG_EXPECTED_PORT};
    val = '{$urandom(), len_word, addr, {16'($urandom()), port}};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    file_len  = len_word[OFF_W-1:0];
    peer_addr = addr;
    peer_port = port;
    setting_count++;
  endtask

  // Send the whole file in window-sized blocks, shuffled inside each block.
  task automatic send_file_blocks();
    int               order [WINDOW_SLOTS];
    int               nseg;
    int               cnt;
    int               pick;
    int               tmp;
    int               span;
    logic [OFF_W-1:0] seg_off;
    logic [OFF_W-1:0] head;
    nseg = int'((file_len - win_base + SEGMENT_BYTES - 1) / SEGMENT_BYTES);
    for (int blk = 0; blk < nseg; blk += WINDOW_SLOTS) begin
      cnt = 0;
      for (int k = blk; k < nseg && k < blk + WINDOW_SLOTS; k++) begin
        order[cnt] = k;
        cnt++;
      end
      for (int j = cnt - 1; j > 0; j--) begin
        pick = $urandom_range(0, j);
        tmp = order[j];
        order[j] = order[pick];
        order[pick] = tmp;
      end
      head = win_base + OFF_W'(blk * SEGMENT_BYTES);
      for (int j = 0; j < cnt; j++) begin
        if ($urandom_range(0, 5) == 0) send_seg(noise_seg(head));
        seg_off = win_base + OFF_W'(order[j] * SEGMENT_BYTES);
        span = int'(file_len - seg_off);
        if (span > SEGMENT_BYTES) span = SEGMENT_BYTES;
        send_seg(good_seg(seg_off + OFF_W'($urandom_range(0, span - 1)), random_tag()));
        random_done++;
      end
    end
    settle();
    win_base = file_len;
  endtask

  initial begin
    int               pick;
    logic [OFF_W-1:0] len;
    logic [ADDR_W-1:0] addr;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_FILE_LENGTH;
    cfg_wdata_i  <= '0;
    seg_ch.valid <= 1'b0;
    seg_ch.data  <= '0;
    file_len      = '0;
    win_base      = '0;
    peer_addr     = '0;
    peer_port     = '0;
    sent_count    = 0;
    setting_count = 0;
    random_done   = 0;
    burst_left    = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the reset length of zero the file counts as complete.
    send_seg(good_seg('0, 16'h1234));
    send_seg(make_seg(OFF_MAX, '1, '1, '1, 1'b0));
    settle();

    // Short file with a partial last segment; upper data bits must be dropped.
    configure({2'b11, 30'd5500}, $urandom(), 16'($urandom()));
    send_seg(make_seg('0, 16'h0001, peer_addr ^ 32'h1, peer_port, 1'b1));
    send_seg(make_seg('0, 16'h0002, peer_addr, peer_port ^ 16'h8000, 1'b1));
    send_seg(make_seg('0, 16'h0003, peer_addr, peer_port, 1'b0));
    send_seg(good_seg(30'd2007, 16'haaaa));
    send_seg(good_seg(30'd1999, 16'hbbbb));
    send_seg(good_seg(30'd5500, 16'h0bad));
    // A duplicate replaces the stored tag; the head then releases three in order.
    send_seg(good_seg(30'd2000, 16'hcccc));
    send_seg(good_seg(30'd0, 16'h0000));
    send_seg(good_seg(30'd2999, 16'h0bad));
    send_seg(good_seg(30'd4499, 16'hffff));
    send_seg(good_seg(30'd5499, 16'h5555));
    send_seg(good_seg(30'd3000, 16'h3333));
    send_seg(good_seg(30'd5000, 16'h0bad));
    settle();
    win_base = file_len;

    // Length change mid-transfer with an all-zero peer: a stored slot is left stranded.
    configure(32'(win_base + 30'd3000), '0, '0);
    send_seg(good_seg(win_base + 30'd1250, 16'h1111));
    send_seg(good_seg(win_base + 30'd2999, 16'h2222));
    settle();
    configure(32'(win_base + 30'd1500), '0, '0);
    send_seg(good_seg(win_base, 16'h4444));
    settle();
    win_base = file_len;

    // A length below the released offset also counts as complete.
    configure(32'(win_base - 30'd700), '0, '0);
    send_seg(good_seg(win_base, 16'h0bad));
    settle();

    // Random whole files of varied size and peer, noise mixed in.
    while (random_done < RANDOM_SEGMENTS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       len = 30'd1;
        1:       len = OFF_W'($urandom_range(1, SEGMENT_BYTES - 1));
        2:       len = OFF_W'(SEGMENT_BYTES * $urandom_range(1, 40));
        default: len = OFF_W'($urandom_range(SEGMENT_BYTES, 45000));
      endcase
      case ($urandom_range(0, 3))
        0:       addr = '0;
        1:       addr = '1;
        default: addr = $urandom();
      endcase
      configure(32'(win_base + len), addr,
                ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom()));
      send_file_blocks();
    end

    // Largest length: window edges and the highest offset.
    configure({2'b00, OFF_MAX}, $urandom(), 16'($urandom()));
    send_seg(good_seg(win_base + OFF_W'(WINDOW_SLOTS * SEGMENT_BYTES - 1), random_tag()));
    send_seg(good_seg(win_base + OFF_W'(WINDOW_SLOTS * SEGMENT_BYTES), random_tag()));
    send_seg(good_seg(OFF_MAX, random_tag()));
    send_seg(good_seg(win_base + 30'd500, random_tag()));
    settle();

    $display("Sent %0d segment requests under %0d register settings; %0d releases checked.",
             sent_count, setting_count, release_count);
    $display("Covered peer and header drops, window and file bounds, reordering, length changes.");
    if (fail_count == 0) begin
      $display("[segment_reorder_window] OK");
    end else begin
      $display("[segment_reorder_window] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sgrw_pkg.sv
design/sgrw_if.sv
design/sgrw_cell.sv
design/segment_reorder_window.sv
design/sgrw_checker.sv
test/sgrw_checker.sv
test/tb_segment_reorder_window.sv
